[rtl/core/udeh_pkg.sv]
// Package for the USB device endpoint handshake engine.
// Holds the field widths, the action, token and handshake codes and the request type.
// It depends on nothing and is used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package udeh_pkg;

  localparam int ENDPOINTS = 16;
  localparam int EP_W      = 4;
  localparam int EP_SLOTS  = 2 ** EP_W;
  localparam int LEN_W     = 10;
  localparam int BUF_AW    = EP_W + 2;
  localparam int BUF_CNT   = 2 ** BUF_AW;

  localparam logic [2:0] ACT_TOKEN    = 3'd0;
  localparam logic [2:0] ACT_QUEUE_RX = 3'd1;
  localparam logic [2:0] ACT_QUEUE_TX = 3'd2;
  localparam logic [2:0] ACT_STALL    = 3'd3;
  localparam logic [2:0] ACT_ENABLE   = 3'd4;

  localparam logic [1:0] TOK_SETUP    = 2'd0;
  localparam logic [1:0] TOK_OUT      = 2'd1;
  localparam logic [1:0] TOK_IN       = 2'd2;
  localparam logic [1:0] TOK_RESERVED = 2'd3;

  localparam logic [2:0] HS_NONE    = 3'd0;
  localparam logic [2:0] HS_ACK     = 3'd1;
  localparam logic [2:0] HS_NAK     = 3'd2;
  localparam logic [2:0] HS_STALL   = 3'd3;
  localparam logic [2:0] HS_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [2:0]       action;
    logic [EP_W-1:0]  endpoint;
    logic [1:0]       token;
    logic             buf_select;
    logic [LEN_W-1:0] length;
  } request_t;

endpackage

`default_nettype wire

[rtl/core/udeh_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// The read data holds its value while no read is enabled. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module udeh_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/usb_device_endpoint_handshake.sv]
// Top level of the USB device endpoint handshake engine.
// Depends on udeh_pkg and on udeh_ram, which holds the buffer capacities.
//
// Usage: each request on the in_ channel is either a host token (SETUP, OUT,
// IN) or a software action (queue a receive or transmit buffer, stall an
// endpoint, enable transfers). Every request yields exactly one result on the
// out_ channel; software actions answer with handshake none.
// A request is taken at the edge at which in_valid is high and in_stall low.
// The capacity memory is read at that edge. When the output register is free
// or draining, the flags are then checked and updated, the capacity is written
// for queue actions and the result is loaded into the output register. The
// engine takes no new request while one waits in the work stage, a limit set
// by the read-modify-write turn through the capacity memory.
// While the receiver stalls, the result holds and one further request may
// be taken and waits in the work stage until the output register frees.
// Reset clears transfer enable, stall, ping-pong and ready flags at once;
// no clearing pass is needed and requests are taken as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module usb_device_endpoint_handshake (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [2:0]                in_action,
  input  wire logic [udeh_pkg::EP_W-1:0] in_endpoint,
  input  wire logic [1:0]                in_token,
  input  wire logic                      in_buf_select,
  input  wire logic [udeh_pkg::LEN_W-1:0] in_length,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     out_handshake,
  output logic                           out_short_packet,
  output logic                           out_done_buffer,
  output logic [1:0]                     out_done_token,
  output logic [udeh_pkg::LEN_W-1:0]     out_done_length,
  output logic [udeh_pkg::LEN_W-1:0]     out_sent_length
);

  logic                              xen_r, xen_nxt;
  logic [udeh_pkg::EP_SLOTS-1:0]     stalled_r, stalled_nxt;
  logic [udeh_pkg::EP_SLOTS-1:0]     rx_pp_r, rx_pp_nxt;
  logic [udeh_pkg::EP_SLOTS-1:0]     tx_pp_r, tx_pp_nxt;
  logic [udeh_pkg::BUF_CNT-1:0]      ready_r, ready_nxt;

  logic                              s1_valid_r, s1_valid_nxt;
  udeh_pkg::request_t                s1_r;
  logic                              out_valid_r, out_valid_nxt;

  logic [2:0]                        hs_nxt;
  logic                              short_nxt;
  logic                              dbuf_nxt;
  logic [1:0]                        dtok_nxt;
  logic [udeh_pkg::LEN_W-1:0]        dlen_nxt;
  logic [udeh_pkg::LEN_W-1:0]        sent_nxt;

  logic                              accept;
  logic                              commit;
  logic                              in_dir;
  logic [udeh_pkg::BUF_AW-1:0]       rd_addr;
  logic [udeh_pkg::LEN_W-1:0]        cap;

  logic                              ep_ok;
  logic                              cur_dir;
  logic                              cur_sel;
  logic [udeh_pkg::BUF_AW-1:0]       cur_buf;
  logic                              setup0;
  logic                              is_queue;
  logic                              wr_en;
  logic [udeh_pkg::BUF_AW-1:0]       wr_addr;

  udeh_pkg::request_t                in_req;

  assign in_req = '{action: in_action, endpoint: in_endpoint, token: in_token,
                    buf_select: in_buf_select, length: in_length};

  assign in_stall  = s1_valid_r;
  assign accept    = in_valid && !s1_valid_r;
  assign commit    = s1_valid_r && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  assign in_dir  = (in_token == udeh_pkg::TOK_IN);
  assign rd_addr = {in_endpoint, in_dir,
                    in_dir ? tx_pp_r[in_endpoint] : rx_pp_r[in_endpoint]};

  assign ep_ok    = (int'(s1_r.endpoint) < udeh_pkg::ENDPOINTS);
  assign cur_dir  = (s1_r.token == udeh_pkg::TOK_IN);
  assign cur_sel  = cur_dir ? tx_pp_r[s1_r.endpoint] : rx_pp_r[s1_r.endpoint];
  assign cur_buf  = {s1_r.endpoint, cur_dir, cur_sel};
  assign setup0   = (s1_r.endpoint == '0) && (s1_r.token == udeh_pkg::TOK_SETUP);
  assign is_queue = (s1_r.action == udeh_pkg::ACT_QUEUE_RX) ||
                    (s1_r.action == udeh_pkg::ACT_QUEUE_TX);
  assign wr_en    = commit && is_queue && ep_ok;
  assign wr_addr  = {s1_r.endpoint, (s1_r.action == udeh_pkg::ACT_QUEUE_TX),
                     s1_r.buf_select};

  udeh_ram #(
    .WIDTH (udeh_pkg::LEN_W),
    .DEPTH (udeh_pkg::BUF_CNT)
  ) u_cap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s1_r.length),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (cap)
  );

  always_comb begin
    xen_nxt     = xen_r;
    stalled_nxt = stalled_r;
    rx_pp_nxt   = rx_pp_r;
    tx_pp_nxt   = tx_pp_r;
    ready_nxt   = ready_r;
    hs_nxt      = udeh_pkg::HS_NONE;
    short_nxt   = 1'b0;
    dbuf_nxt    = 1'b0;
    dtok_nxt    = 2'd0;
    dlen_nxt    = '0;
    sent_nxt    = '0;
    case (s1_r.action)
      udeh_pkg::ACT_TOKEN: begin
        if (s1_r.token != udeh_pkg::TOK_RESERVED) begin
          if (!xen_r || !ep_ok) begin
            hs_nxt = udeh_pkg::HS_TIMEOUT;
          end else if (stalled_r[s1_r.endpoint] && !setup0) begin
            hs_nxt = udeh_pkg::HS_STALL;
          end else if (!ready_r[cur_buf]) begin
            hs_nxt = udeh_pkg::HS_NAK;
          end else begin
            hs_nxt             = udeh_pkg::HS_ACK;
            ready_nxt[cur_buf] = 1'b0;
            if (cur_dir) begin
              tx_pp_nxt[s1_r.endpoint] = !cur_sel;
              sent_nxt                 = cap;
            end else begin
              rx_pp_nxt[s1_r.endpoint] = !cur_sel;
            end
            short_nxt = (s1_r.length > cap);
            dbuf_nxt  = cur_sel;
            dtok_nxt  = s1_r.token;
            dlen_nxt  = s1_r.length;
          end
          if (xen_r && ep_ok && setup0) begin
            stalled_nxt[0] = 1'b0;
            xen_nxt        = 1'b0;
          end
        end
      end
      udeh_pkg::ACT_QUEUE_RX, udeh_pkg::ACT_QUEUE_TX: begin
        if (ep_ok) begin
          ready_nxt[wr_addr] = 1'b1;
        end
      end
      udeh_pkg::ACT_STALL: begin
        if (ep_ok) begin
          stalled_nxt[s1_r.endpoint] = 1'b1;
        end
      end
      udeh_pkg::ACT_ENABLE: begin
        xen_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (commit) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xen_r       <= 1'b0;
      stalled_r   <= '0;
      rx_pp_r     <= '0;
      tx_pp_r     <= '0;
      ready_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        xen_r     <= xen_nxt;
        stalled_r <= stalled_nxt;
        rx_pp_r   <= rx_pp_nxt;
        tx_pp_r   <= tx_pp_nxt;
        ready_r   <= ready_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_req;
    end
    if (commit) begin
      out_handshake    <= hs_nxt;
      out_short_packet <= short_nxt;
      out_done_buffer  <= dbuf_nxt;
      out_done_token   <= dtok_nxt;
      out_done_length  <= dlen_nxt;
      out_sent_length  <= sent_nxt;
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for usb_device_endpoint_handshake: a queue of directed and random
// requests feeds a bursty driver, and a stalling monitor checks every answer against a predictor.
// Depends on udeh_pkg and the top level of the RTL.

module tb;
  import udeh_pkg::*;

  localparam logic [1:0] TOK_RESERVED    = 2'd3;
  localparam logic [2:0] ACT_SPARE_LO    = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI    = 3'd7;
  localparam int         RANDOM_REQUESTS = 850;
  localparam int         DRAIN_CYCLES    = 10;

  typedef struct packed {
    logic [2:0]       handshake;
    logic             short_packet;
    logic             done_buffer;
    logic [1:0]       done_token;
    logic [LEN_W-1:0] done_length;
    logic [LEN_W-1:0] sent_length;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       in_action = '0;
  logic [EP_W-1:0]  in_endpoint = '0;
  logic [1:0]       in_token = '0;
  logic             in_buf_select = 1'b0;
  logic [LEN_W-1:0] in_length = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       out_handshake;
  logic             out_short_packet;
  logic             out_done_buffer;
  logic [1:0]       out_done_token;
  logic [LEN_W-1:0] out_done_length;
  logic [LEN_W-1:0] out_sent_length;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  request_t driven_request;
  answer_t  oldest_answer;
  int       fail_count = 0;
  int       total_requests = 0;
  int       accepted_requests = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_mode = 0;
  int       mode_cycles = 0;
  int       stall_run = 0;
  logic     hold_stall = 1'b0;

  logic                 xfers_on = 1'b0;
  logic [ENDPOINTS-1:0] ep_halted = '0;
  logic [ENDPOINTS-1:0] rx_side = '0;
  logic [ENDPOINTS-1:0] tx_side = '0;
  logic [BUF_CNT-1:0]   buf_armed = '0;
  logic [LEN_W-1:0]     buf_cap [BUF_CNT];

  usb_device_endpoint_handshake dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_endpoint      (in_endpoint),
    .in_token         (in_token),
    .in_buf_select    (in_buf_select),
    .in_length        (in_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_handshake    (out_handshake),
    .out_short_packet (out_short_packet),
    .out_done_buffer  (out_done_buffer),
    .out_done_token   (out_done_token),
    .out_done_length  (out_done_length),
    .out_sent_length  (out_sent_length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic answer_t answer_request(request_t req);
    answer_t           ans;
    logic              dir;
    logic              sel;
    logic [BUF_AW-1:0] slot;
    ans = '0;
    ans.handshake = HS_NONE;
    case (req.action)
      ACT_TOKEN: begin
        if (req.token != TOK_RESERVED) begin
          if (!xfers_on) begin
            ans.handshake = HS_TIMEOUT;
          end else begin
            if (req.endpoint == '0 && req.token == TOK_SETUP) begin
              ep_halted[0] = 1'b0;
              xfers_on = 1'b0;
            end
            dir = (req.token == TOK_IN);
            sel = dir ? tx_side[req.endpoint] : rx_side[req.endpoint];
            slot = {req.endpoint, dir, sel};
            if (ep_halted[req.endpoint]) begin
              ans.handshake = HS_STALL;
            end else if (!buf_armed[slot]) begin
              ans.handshake = HS_NAK;
            end else begin
              buf_armed[slot] = 1'b0;
              if (dir) begin
                tx_side[req.endpoint] = ~tx_side[req.endpoint];
              end else begin
                rx_side[req.endpoint] = ~rx_side[req.endpoint];
              end
              ans.handshake = HS_ACK;
              ans.short_packet = (req.length > buf_cap[slot]);
              ans.done_buffer = sel;
              ans.done_token = req.token;
              ans.done_length = req.length;
              ans.sent_length = dir ? buf_cap[slot] : '0;
            end
          end
        end
      end
      ACT_QUEUE_RX, ACT_QUEUE_TX: begin
        slot = {req.endpoint, req.action == ACT_QUEUE_TX, req.buf_select};
        buf_cap[slot] = req.length;
        buf_armed[slot] = 1'b1;
      end
      ACT_STALL: begin
        ep_halted[req.endpoint] = 1'b1;
      end
      ACT_ENABLE: begin
        xfers_on = 1'b1;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic add_request(input logic [2:0] act, input logic [EP_W-1:0] ep,
                             input logic [1:0] tok, input logic sel,
                             input logic [LEN_W-1:0] len);
    request_t req;
    req.action = act;
    req.endpoint = ep;
    req.token = tok;
    req.buf_select = sel;
    req.length = len;
    pending_requests.push_back(req);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll <= 3) return LEN_W'($urandom_range(0, 16));
    return LEN_W'($urandom_range(0, 2 ** LEN_W - 1));
  endfunction

  function automatic logic [EP_W-1:0] pick_endpoint();
    if ($urandom_range(0, 1) == 0) return EP_W'($urandom_range(0, 3));
    return EP_W'($urandom_range(0, ENDPOINTS - 1));
  endfunction

  function automatic logic [EP_W-1:0] pick_stall_endpoint();
    if ($urandom_range(0, 4) != 0) return '0;
    return EP_W'($urandom_range(0, ENDPOINTS - 1));
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_answers.push_back(answer_request(driven_request));
        accepted_requests++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          driven_request = pending_requests.pop_front();
          in_action <= driven_request.action;
          in_endpoint <= driven_request.endpoint;
          in_token <= driven_request.token;
          in_buf_select <= driven_request.buf_select;
          in_length <= driven_request.length;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result: handshake %0d with no request pending", out_handshake);
        fail_count++;
      end else begin
        oldest_answer = expected_answers.pop_front();
        check_field("handshake", 16'(oldest_answer.handshake), 16'(out_handshake));
        check_field("short_packet", 16'(oldest_answer.short_packet), 16'(out_short_packet));
        check_field("done_buffer", 16'(oldest_answer.done_buffer), 16'(out_done_buffer));
        check_field("done_token", 16'(oldest_answer.done_token), 16'(out_done_token));
        check_field("done_length", 16'(oldest_answer.done_length), 16'(out_done_length));
        check_field("sent_length", 16'(oldest_answer.sent_length), 16'(out_sent_length));
      end
    end
    if (mode_cycles == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_cycles = $urandom_range(20, 120);
    end else begin
      mode_cycles--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: begin
        if (stall_run == 0) begin
          hold_stall = ~hold_stall;
          stall_run = hold_stall ? $urandom_range(1, 15) : $urandom_range(1, 4);
        end else begin
          stall_run--;
        end
        out_stall <= hold_stall;
      end
    endcase
  end

  initial begin
    int              goal;
    int              spare;
    int              roll;
    int              nq;
    int              nt;
    logic [EP_W-1:0] ep;
    logic            dir;
    logic [1:0]      tok;

    // Directed requests: disabled transfers, ready and not ready buffers,
    // capacity overwrite, both ping-pong sides, stalls, and the setup that
    // clears the stall on endpoint zero while disabling transfers.
    add_request(ACT_TOKEN, 4'd5, TOK_IN, 1'b1, '1);
    add_request(ACT_ENABLE, '1, TOK_RESERVED, 1'b1, '1);
    add_request(ACT_TOKEN, 4'd1, TOK_OUT, 1'b0, 10'd10);
    add_request(ACT_QUEUE_RX, 4'd1, TOK_IN, 1'b0, '0);
    add_request(ACT_QUEUE_RX, 4'd1, TOK_SETUP, 1'b0, '1);
    add_request(ACT_TOKEN, 4'd1, TOK_OUT, 1'b1, '1);
    add_request(ACT_QUEUE_RX, 4'd1, TOK_OUT, 1'b1, '0);
    add_request(ACT_TOKEN, 4'd1, TOK_OUT, 1'b0, 10'd1);
    add_request(ACT_QUEUE_TX, '1, TOK_RESERVED, 1'b0, '1);
    add_request(ACT_TOKEN, '1, TOK_IN, 1'b1, '0);
    add_request(ACT_QUEUE_TX, '1, TOK_IN, 1'b1, 10'd100);
    add_request(ACT_TOKEN, '1, TOK_IN, 1'b0, 10'd101);
    add_request(ACT_STALL, '1, TOK_OUT, 1'b1, '1);
    add_request(ACT_TOKEN, '1, TOK_IN, 1'b0, 10'd4);
    add_request(ACT_STALL, '0, TOK_IN, 1'b0, '0);
    add_request(ACT_TOKEN, '0, TOK_OUT, 1'b1, 10'd8);
    add_request(ACT_QUEUE_RX, '0, TOK_SETUP, 1'b0, 10'd8);
    add_request(ACT_TOKEN, '0, TOK_SETUP, 1'b1, 10'd8);
    add_request(ACT_TOKEN, '0, TOK_OUT, 1'b0, 10'd3);
    add_request(ACT_TOKEN, 4'd3, TOK_RESERVED, 1'b1, '1);
    add_request(3'd5, 4'd6, TOK_IN, 1'b0, 10'd7);
    add_request(3'd6, 4'd9, TOK_OUT, 1'b1, 10'd512);
    add_request(ACT_SPARE_HI, '1, TOK_RESERVED, 1'b1, '1);
    add_request(ACT_ENABLE, '0, TOK_SETUP, 1'b0, '0);
    add_request(ACT_TOKEN, 4'd2, TOK_SETUP, 1'b0, 10'd64);

    goal = pending_requests.size() + RANDOM_REQUESTS;
    spare = 0;
    while (pending_requests.size() - spare < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        ep = pick_endpoint();
        dir = $urandom_range(0, 1);
        if ($urandom_range(0, 2) == 0) begin
          add_request(ACT_ENABLE, EP_W'($urandom), 2'($urandom), 1'($urandom),
                      LEN_W'($urandom));
        end
        nq = $urandom_range(1, 2);
        for (int k = 0; k < nq; k++) begin
          add_request(dir ? ACT_QUEUE_TX : ACT_QUEUE_RX, ep, 2'($urandom),
                      (nq == 2) ? 1'(k) : 1'($urandom), pick_length());
        end
        nt = $urandom_range(1, 3);
        for (int k = 0; k < nt; k++) begin
          if (dir) tok = TOK_IN;
          else tok = ($urandom_range(0, 3) == 0) ? TOK_SETUP : TOK_OUT;
          add_request(ACT_TOKEN, ep, tok, 1'($urandom), pick_length());
        end
      end else if (roll < 90) begin
        case ($urandom_range(0, 4))
          0: add_request(ACT_TOKEN, pick_endpoint(), 2'($urandom_range(0, 2)),
                         1'($urandom), pick_length());
          1: add_request(ACT_QUEUE_RX, pick_endpoint(), 2'($urandom), 1'($urandom),
                         pick_length());
          2: add_request(ACT_QUEUE_TX, pick_endpoint(), 2'($urandom), 1'($urandom),
                         pick_length());
          3: add_request(ACT_STALL, pick_stall_endpoint(), 2'($urandom), 1'($urandom),
                         LEN_W'($urandom));
          default: add_request(ACT_ENABLE, EP_W'($urandom), 2'($urandom), 1'($urandom),
                               LEN_W'($urandom));
        endcase
      end else if (roll < 95) begin
        add_request(ACT_STALL, pick_stall_endpoint(), 2'($urandom), 1'($urandom),
                    LEN_W'($urandom));
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          add_request(ACT_TOKEN, pick_endpoint(), TOK_RESERVED, 1'($urandom), pick_length());
        end else begin
          add_request(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), EP_W'($urandom),
                      2'($urandom), 1'($urandom), LEN_W'($urandom));
        end
        spare++;
      end
    end
    total_requests = pending_requests.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_requests < total_requests) @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
